// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: hw/rtl/ohash_pkg.sv
// ----------------------------------------------------------------------------
// ohash_pkg
// shared widths, codes and defaults of the hash table engine
// ----------------------------------------------------------------------------
package ohash_pkg;

    localparam int ACTION_W = 2;
    localparam int KEY_W    = 64;
    localparam int LEN_W    = 4;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 8;
    localparam int CFG_W    = 9;

    localparam int TS_RESET       = 256;
    localparam int SLOTS_DEF      = 256;
    localparam int KEY_BYTES_DEF  = 8;
    localparam int MAX_PROBES_DEF = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_FIND   = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_LIMIT     = 3'd3,
        ST_CLEARED   = 3'd4
    } t_status;

endpackage

// File: hw/rtl/ohash_req_if.sv
// ----------------------------------------------------------------------------
// ohash_req_if
// request channel: action, key and key length
// ----------------------------------------------------------------------------
interface ohash_req_if;
    import ohash_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    key;
    logic [LEN_W-1:0]    key_len;

    modport source (output valid, action, key, key_len, input ready);
    modport sink   (input valid, action, key, key_len, output ready);
endinterface

// File: hw/rtl/ohash_rsp_if.sv
// ----------------------------------------------------------------------------
// ohash_rsp_if
// response channel: status and slot
// ----------------------------------------------------------------------------
interface ohash_rsp_if;
    import ohash_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;

    modport source (output valid, status, slot, input ready);
    modport sink   (input valid, status, slot, output ready);
endinterface

// File: hw/rtl/ohash_cfg_if.sv
// ----------------------------------------------------------------------------
// ohash_cfg_if
// configuration write channel for the table size register
// ----------------------------------------------------------------------------
interface ohash_cfg_if;
    import ohash_pkg::*;

    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: hw/rtl/open_addressing_hash_table.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// sequence: home slot by one step of the shared compare/subtract unit per sum
//   bit (11 bits for 8 key bytes), then memory read and compare per probe, with
//   offset and position steps before each further probe, then response out
// clear request: sweeps all SLOTS rows, one memory row written per cycle
// throughput: one request at a time, next one taken the cycle after the response
//   is posted; a response still held by the sink stalls the posting
// reset: sweeps all SLOTS rows of the slot memory (no requests)
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module open_addressing_hash_table #(
    parameter int SLOTS      = ohash_pkg::SLOTS_DEF,
    parameter int KEY_BYTES  = ohash_pkg::KEY_BYTES_DEF,
    parameter int MAX_PROBES = ohash_pkg::MAX_PROBES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ohash_req_if.sink    i_req,
    ohash_rsp_if.source  o_rsp,
    ohash_cfg_if.sink    i_cfg
);
    import ohash_pkg::*;

    localparam int PW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TSW     = $clog2(SLOTS + 1);
    localparam int KBW     = 8 * KEY_BYTES;
    localparam int SUMW    = $clog2(KEY_BYTES * 255 + 1);
    localparam int KW      = $clog2(SUMW);
    localparam int DW      = SUMW + TSW;
    localparam int NW      = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
    localparam int MW      = 1 + LEN_W + KBW;
    localparam int TS_INIT = (TS_RESET > SLOTS) ? SLOTS : TS_RESET;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_HOME,
        S_READ,
        S_CHECK,
        S_OFF,
        S_POS,
        S_DONE
    } t_state;

    t_state            r_state;
    t_action           r_act;
    t_status           r_res_status;
    logic [SLOT_W-1:0] r_res_slot;
    logic [TSW-1:0]    r_ts;
    logic [SUMW-1:0]   r_x;
    logic [KW-1:0]     r_k;
    logic [PW-1:0]     r_pos;
    logic [PW-1:0]     r_off;
    logic [NW-1:0]     r_n;
    logic [KBW-1:0]    r_key;
    logic [LEN_W-1:0]  r_len;
    logic              r_clr;
    logic              r_ov;
    logic [STATUS_W-1:0] r_status;
    logic [SLOT_W-1:0] r_slot;

    logic [MW-1:0]     mem [SLOTS];
    logic [MW-1:0]     r_rdata;

    logic [LEN_W-1:0]  len_c;
    logic [KBW-1:0]    key_m;
    logic [SUMW-1:0]   sum;
    logic [DW-1:0]     cs_x;
    logic [DW-1:0]     cs_d;
    logic [DW-1:0]     cs_res;
    logic              mem_we;
    logic [MW-1:0]     mem_wd;
    logic              rd_used;
    logic              rd_match;

    // request key: clamp length and clear unused bytes, sum for home slot
    always_comb begin
        if (i_req.key_len == '0) begin
            len_c = LEN_W'(1);
        end else if (i_req.key_len > LEN_W'(KEY_BYTES)) begin
            len_c = LEN_W'(KEY_BYTES);
        end else begin
            len_c = i_req.key_len;
        end
    end

    always_comb begin
        key_m = '0;
        sum   = '0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            if (LEN_W'(b) < len_c) begin
                key_m[8*b +: 8] = i_req.key[8*b +: 8];
                sum = sum + SUMW'(i_req.key[8*b +: 8]);
            end
        end
    end

    // operand select for the shared unit
    always_comb begin
        case (r_state)
            S_OFF: begin
                cs_x = DW'({r_off, 1'b1});
                cs_d = DW'(r_ts);
            end
            S_POS: begin
                cs_x = DW'(r_pos) + DW'(r_off);
                cs_d = DW'(r_ts);
            end
            default: begin
                cs_x = DW'(r_x);
                cs_d = DW'(r_ts) << r_k;
            end
        endcase
    end

    ohash_cmpsub #(
        .W (DW)
    ) u_cmpsub (
        .i_x   (cs_x),
        .i_d   (cs_d),
        .o_res (cs_res)
    );

    assign rd_used  = r_rdata[MW-1];
    assign rd_match = (r_rdata[KBW-1:0] == r_key) && (r_rdata[KBW +: LEN_W] == r_len);

    assign mem_we = (r_state == S_SWEEP)
                 || ((r_state == S_CHECK) && !rd_used && (r_act == ACT_INSERT));
    assign mem_wd = (r_state == S_SWEEP) ? '0 : {1'b1, r_len, r_key};

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_pos] <= mem_wd;
        end
        r_rdata <= mem[r_pos];
    end

    assign i_req.ready  = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign o_rsp.valid  = r_ov;
    assign o_rsp.status = r_status;
    assign o_rsp.slot   = r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_pos   <= '0;
            r_clr   <= 1'b0;
            r_ov    <= 1'b0;
            r_ts    <= TSW'(TS_INIT);
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.data < CFG_W'(2)) begin
                    r_ts <= TSW'(2);
                end else if (32'(i_cfg.data) > SLOTS) begin
                    r_ts <= TSW'(SLOTS);
                end else begin
                    r_ts <= TSW'(i_cfg.data);
                end
            end

            if (o_rsp.valid && o_rsp.ready && (r_state != S_DONE)) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_SWEEP: begin
                    if (r_pos == PW'(SLOTS - 1)) begin
                        r_pos <= '0;
                        if (r_clr) begin
                            r_res_status <= ST_CLEARED;
                            r_res_slot   <= '0;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_pos <= r_pos + PW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_act <= t_action'(i_req.action);
                        r_key <= key_m;
                        r_len <= len_c;
                        r_x   <= sum;
                        r_k   <= KW'(SUMW - 1);
                        r_off <= '0;
                        r_n   <= '0;
                        case (t_action'(i_req.action))
                            ACT_INSERT, ACT_FIND: begin
                                r_state <= S_HOME;
                            end
                            ACT_CLEAR: begin
                                r_clr   <= 1'b1;
                                r_pos   <= '0;
                                r_state <= S_SWEEP;
                            end
                            default: begin
                                r_res_status <= ST_NOT_FOUND;
                                r_res_slot   <= '0;
                                r_state      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_HOME: begin
                    r_x <= SUMW'(cs_res);
                    if (r_k == '0) begin
                        r_pos   <= PW'(cs_res);
                        r_state <= S_READ;
                    end else begin
                        r_k <= r_k - KW'(1);
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (!rd_used) begin
                        if (r_act == ACT_INSERT) begin
                            r_res_status <= ST_INSERTED;
                            r_res_slot   <= SLOT_W'(r_pos);
                        end else begin
                            r_res_status <= ST_NOT_FOUND;
                            r_res_slot   <= '0;
                        end
                        r_state <= S_DONE;
                    end else if ((r_act == ACT_FIND) && rd_match) begin
                        r_res_status <= ST_FOUND;
                        r_res_slot   <= SLOT_W'(r_pos);
                        r_state      <= S_DONE;
                    end else if (r_n == NW'(MAX_PROBES - 1)) begin
                        r_res_status <= ST_LIMIT;
                        r_res_slot   <= '0;
                        r_state      <= S_DONE;
                    end else begin
                        r_state <= S_OFF;
                    end
                end
                S_OFF: begin
                    r_off   <= PW'(cs_res);
                    r_state <= S_POS;
                end
                S_POS: begin
                    r_pos   <= PW'(cs_res);
                    r_n     <= r_n + NW'(1);
                    r_state <= S_READ;
                end
                S_DONE: begin
                    if (!r_ov || o_rsp.ready) begin
                        r_ov     <= 1'b1;
                        r_status <= r_res_status;
                        r_slot   <= r_res_slot;
                        r_clr    <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_AT(a_pos_in_table, i_clk, i_rst_n, (r_state == S_READ) |-> (32'(r_pos) < 32'(r_ts)), "probe position outside table")
    `ASSERT_AT(a_off_in_table, i_clk, i_rst_n, (r_state == S_POS) |-> (32'(r_off) < 32'(r_ts)), "probe offset not reduced")
    `ASSERT_AT(a_probe_bound, i_clk, i_rst_n, (r_state == S_CHECK) |-> (32'(r_n) < MAX_PROBES), "probe count past limit")
    `ASSERT_NEVER(a_no_idle_overwrite, i_clk, i_rst_n, (r_state == S_IDLE) && $past(r_state == S_DONE) && !r_ov, "result lost on way to output")

endmodule

// File: hw/rtl/ohash_cmpsub.sv
// ----------------------------------------------------------------------------
// ohash_cmpsub
// shared compare and conditional subtract unit used for every modulo step
// ----------------------------------------------------------------------------
module ohash_cmpsub #(
    parameter int W = 8
) (
    input  logic [W-1:0] i_x,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_res
);

    logic ge;

    assign ge    = (i_x >= i_d);
    assign o_res = ge ? (i_x - i_d) : i_x;

endmodule
